/* rtl/core/bba_pkg.sv */
package bba_pkg;

	localparam int CW    = 24;
	localparam int AXES  = 3;
	localparam int CNT_W = $clog2(CW);

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic   start_req;
		coord_t lo_x;
		coord_t lo_y;
		coord_t lo_z;
		coord_t hi_x;
		coord_t hi_y;
		coord_t hi_z;
	} in_t;

	typedef struct packed {
		coord_t     min_x;
		coord_t     min_y;
		coord_t     min_z;
		coord_t     max_x;
		coord_t     max_y;
		coord_t     max_z;
		coord_t     center_x;
		coord_t     center_y;
		coord_t     center_z;
		logic [CW-1:0] half_diagonal;
	} out_t;

	// index 0 = x, 1 = y, 2 = z
	typedef struct packed {
		coord_t [AXES-1:0] lo;
		coord_t [AXES-1:0] hi;
	} box_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic full;
		logic empty;
	} q_ctl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SQ,
		BK_ROOT,
		BK_DONE
	} back_state_t;

endpackage

/* rtl/core/bba_front.sv */
module bba_front (
	input  logic          clk,
	input  logic          arst_n,
	input  bba_pkg::in_t  item,
	input  logic          accept,
	output bba_pkg::box_t merged
);

	bba_pkg::coord_t [bba_pkg::AXES-1:0] box_lo_q;
	bba_pkg::coord_t [bba_pkg::AXES-1:0] box_hi_q;
	logic                                empty_q;
	bba_pkg::coord_t [bba_pkg::AXES-1:0] in_lo;
	bba_pkg::coord_t [bba_pkg::AXES-1:0] in_hi;
	logic                                take;

	assign in_lo = {item.lo_z, item.lo_y, item.lo_x};
	assign in_hi = {item.hi_z, item.hi_y, item.hi_x};
	assign take  = item.start_req || empty_q;

	always_comb begin
		for (int i = 0; i < bba_pkg::AXES; i++) begin
			if (take || (in_lo[i] < box_lo_q[i])) begin
				merged.lo[i] = in_lo[i];
			end else begin
				merged.lo[i] = box_lo_q[i];
			end
			if (take || (in_hi[i] > box_hi_q[i])) begin
				merged.hi[i] = in_hi[i];
			end else begin
				merged.hi[i] = box_hi_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
		end else if (accept) begin
			empty_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_lo_q <= merged.lo;
			box_hi_q <= merged.hi;
		end
	end

endmodule

/* rtl/core/bba_queue.sv */
module bba_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  bba_pkg::box_t    wr_data,
	output bba_pkg::box_t    rd_data,
	input  bba_pkg::q_ctl_t  ctl_in,
	output bba_pkg::q_ctl_t  ctl_out
);

	bba_pkg::box_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_wr;
	logic          do_rd;

	assign do_wr = ctl_in.wr && (count_q != 2'd2);
	assign do_rd = ctl_in.rd && (count_q != 2'd0);

	always_comb begin
		ctl_out       = '0;
		ctl_out.wr    = do_wr;
		ctl_out.rd    = do_rd;
		ctl_out.full  = (count_q == 2'd2);
		ctl_out.empty = (count_q == 2'd0);
	end

	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/core/bba_back.sv */
module bba_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bba_pkg::box_t box,
	input  logic          box_avail,
	output logic          box_take,
	output bba_pkg::out_t result,
	output logic          res_valid,
	input  logic          res_pop
);

	localparam int CW = bba_pkg::CW;

	bba_pkg::back_state_t state_q;
	bba_pkg::back_state_t state_nxt;

	bba_pkg::coord_t [bba_pkg::AXES-1:0] lo_q;
	bba_pkg::coord_t [bba_pkg::AXES-1:0] hi_q;
	logic [bba_pkg::CNT_W-1:0]           cnt_q;
	logic [2*CW-1:0]                     sq_q;
	logic [2*CW+1:0]                     sum_q;
	logic [2*CW-1:0]                     rad_q;
	logic [CW+1:0]                       rem_q;
	logic [CW-1:0]                       root_q;
	bba_pkg::out_t                       res_q;
	logic                                res_valid_q;

	logic                                sq_last;
	logic                                root_last;
	logic                                res_load;
	bba_pkg::coord_t                     ax_lo;
	bba_pkg::coord_t                     ax_hi;
	logic signed [CW:0]                  diff;
	logic [CW:0]                         diff_abs;
	logic [CW-1:0]                       mag;
	logic [2*CW-1:0]                     prod;
	logic [2*CW+1:0]                     total;
	logic [CW+3:0]                       rem_sh;
	logic [CW+3:0]                       trial;
	logic [CW+3:0]                       rem_sub;
	logic                                fits;
	logic signed [CW:0]                  csum [bba_pkg::AXES];

	assign sq_last   = (cnt_q == bba_pkg::CNT_W'(bba_pkg::AXES));
	assign root_last = (cnt_q == bba_pkg::CNT_W'(CW - 1));

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				ax_lo = lo_q[0];
				ax_hi = hi_q[0];
			end
			2'd1: begin
				ax_lo = lo_q[1];
				ax_hi = hi_q[1];
			end
			default: begin
				ax_lo = lo_q[2];
				ax_hi = hi_q[2];
			end
		endcase
	end

	assign diff     = {ax_hi[CW-1], ax_hi} - {ax_lo[CW-1], ax_lo};
	assign diff_abs = diff[CW] ? (~diff + 1'b1) : diff;
	assign mag      = diff_abs[CW-1:0];
	assign prod     = mag * mag;
	assign total    = sum_q + {2'b00, sq_q};

	assign rem_sh  = {rem_q, rad_q[2*CW-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign fits    = (rem_sh >= trial);
	assign rem_sub = rem_sh - trial;

	always_comb begin
		for (int i = 0; i < bba_pkg::AXES; i++) begin
			csum[i] = {lo_q[i][CW-1], lo_q[i]} + {hi_q[i][CW-1], hi_q[i]};
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bba_pkg::BK_IDLE: begin
				if (box_avail) begin
					state_nxt = bba_pkg::BK_SQ;
				end
			end
			bba_pkg::BK_SQ: begin
				if (sq_last) begin
					state_nxt = bba_pkg::BK_ROOT;
				end
			end
			bba_pkg::BK_ROOT: begin
				if (root_last) begin
					state_nxt = bba_pkg::BK_DONE;
				end
			end
			bba_pkg::BK_DONE: begin
				if (!res_valid_q) begin
					state_nxt = bba_pkg::BK_IDLE;
				end
			end
			default: state_nxt = bba_pkg::BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		box_take = 1'b0;
		res_load = 1'b0;
		case (state_q)
			bba_pkg::BK_IDLE: box_take = box_avail;
			bba_pkg::BK_DONE: res_load = !res_valid_q;
			default: begin
				box_take = 1'b0;
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bba_pkg::BK_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q != state_nxt) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bba_pkg::BK_IDLE: begin
				lo_q  <= box.lo;
				hi_q  <= box.hi;
				sum_q <= '0;
			end
			bba_pkg::BK_SQ: begin
				if (!sq_last) begin
					sq_q <= prod;
				end
				if (cnt_q != '0) begin
					sum_q <= total;
				end
				if (sq_last) begin
					rad_q  <= total[2*CW+1:2];
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			bba_pkg::BK_ROOT: begin
				rad_q  <= {rad_q[2*CW-3:0], 2'b00};
				rem_q  <= fits ? rem_sub[CW+1:0] : rem_sh[CW+1:0];
				root_q <= {root_q[CW-2:0], fits};
			end
			default: begin
				if (res_load) begin
					res_q.min_x         <= lo_q[0];
					res_q.min_y         <= lo_q[1];
					res_q.min_z         <= lo_q[2];
					res_q.max_x         <= hi_q[0];
					res_q.max_y         <= hi_q[1];
					res_q.max_z         <= hi_q[2];
					res_q.center_x      <= csum[0][CW:1];
					res_q.center_y      <= csum[1][CW:1];
					res_q.center_z      <= csum[2][CW:1];
					res_q.half_diagonal <= root_q;
				end
			end
		endcase
	end

	assign result    = res_q;
	assign res_valid = res_valid_q;

endmodule

/* rtl/core/bounding_box_accumulator.sv */
// Axis-aligned bounding box accumulator, signed Q12.12 coordinates.
// Input queue port: item (push/full), one transaction per box or point;
// start_req opens a new box, otherwise the box merges by per-axis min/max.
// Result queue port: result (empty/pop), one transaction per input, carrying
// the held box, its center and half its diagonal length.
// The merge is done in the front in the accepting cycle; merged boxes wait
// in a two-entry queue. The back squares the three extents in turn with
// one multiplier, then runs a one-bit-per-cycle integer square root, then
// loads the single output register. The back works on one box at a time
// and takes the next from the queue only when idle again; push is taken
// back to back until the queue (two boxes) fills.
// Reset marks the held box, both queues and the output register empty.
// While the receiver stalls, the result holds; the back waits with its next
// result finished, and full rises once two more boxes are queued.
module bounding_box_accumulator (
	input  logic          clk,
	input  logic          arst_n,
	input  bba_pkg::in_t  item,
	input  logic          push,
	output logic          full,
	output bba_pkg::out_t result,
	output logic          empty,
	input  logic          pop
);

	bba_pkg::box_t   merged;
	bba_pkg::box_t   head;
	bba_pkg::q_ctl_t q_in;
	bba_pkg::q_ctl_t q_out;
	logic            accept;
	logic            box_take;
	logic            res_valid;

	assign accept = push && !q_out.full;

	always_comb begin
		q_in       = '0;
		q_in.wr    = accept;
		q_in.rd    = box_take;
	end

	bba_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.accept (accept),
		.merged (merged)
	);

	bba_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (merged),
		.rd_data (head),
		.ctl_in  (q_in),
		.ctl_out (q_out)
	);

	bba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.box       (head),
		.box_avail (!q_out.empty),
		.box_take  (box_take),
		.result    (result),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	assign full  = q_out.full;
	assign empty = !res_valid;

endmodule

/* rtl/core/bba_checker.sv */
module bba_checker (
	input logic          clk,
	input logic          arst_n,
	input bba_pkg::in_t  item,
	input logic          push,
	input logic          full,
	input bba_pkg::out_t result,
	input logic          empty,
	input logic          pop
);

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	// single output slot and multi-cycle back: no result right after a pop
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> empty)
		else $error("result appeared right after a pop");

	// the box queue only fills on push
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose without push");

	// center lies inside a well-formed box
	a_center: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.min_x <= result.max_x)) |->
		((result.center_x >= result.min_x) && (result.center_x <= result.max_x)))
		else $error("center_x outside box");

endmodule

bind bounding_box_accumulator bba_checker u_bba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.item   (item),
	.push   (push),
	.full   (full),
	.result (result),
	.empty  (empty),
	.pop    (pop)
);
